### hdl/jhps_pkg.sv
// Shared types and constants for the JPEG header and payload scanner.
// No dependencies; used by jhps_parser and jpeg_header_and_payload_scanner.
`timescale 1ns / 1ps

package jhps_pkg;

    // Longest image that is walked; later bytes are ignored.
    localparam longint MAX_IMAGE_BYTES = 64'd16777216;
    localparam longint POS_LIMIT_FULL  =
        (MAX_IMAGE_BYTES > 64'h1000000) ? 64'h1000000 : MAX_IMAGE_BYTES;
    localparam int POS_W = $clog2(POS_LIMIT_FULL + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_FULL);

    // Marker bytes
    localparam logic [7:0] MK_FF   = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] SAMP_H2V2 = 8'h22;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SOI    = 3'd1;
    localparam logic [2:0] ST_BAD_FRAME = 3'd2;
    localparam logic [2:0] ST_NO_SOS    = 3'd3;
    localparam logic [2:0] ST_NO_EOI    = 3'd4;

    typedef enum logic [3:0] {
        PH_START,
        PH_SOI,
        PH_FRAME,
        PH_TYPE,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_SCAN,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        subsample_type;
        logic        qtable0_present;
        logic [23:0] qtable0_offset;
        logic        qtable1_present;
        logic [23:0] qtable1_offset;
        logic [23:0] payload_offset;
        logic [23:0] payload_length;
    } result_item_t;

endpackage

### hdl/jhps_parser.sv
// Marker segment walker: per-byte state update and end-of-image summary.
// Depends on jhps_pkg.
`timescale 1ns / 1ps

module jhps_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  jhps_pkg::byte_item_t  item,
    output logic                  res_fire,
    output jhps_pkg::result_item_t res
);

    // SOF0 body offsets (after the length field)
    localparam logic [15:0] SOF_HGT_HI = 16'd1;
    localparam logic [15:0] SOF_HGT_LO = 16'd2;
    localparam logic [15:0] SOF_WID_HI = 16'd3;
    localparam logic [15:0] SOF_WID_LO = 16'd4;
    localparam logic [15:0] SOF_SAMP   = 16'd7;

    jhps_pkg::phase_t             phase_reg, phase_next;
    logic [jhps_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]                  rem_reg, rem_next;
    logic [7:0]                   marker_reg, marker_next;
    logic [15:0]                  idx_reg, idx_next;
    logic [15:0]                  width_reg, width_next;
    logic [15:0]                  height_reg, height_next;
    logic                         type_reg, type_next;
    logic [1:0]                   dqt_cnt_reg, dqt_cnt_next;
    logic [23:0]                  tbl0_reg, tbl0_next;
    logic [23:0]                  tbl1_reg, tbl1_next;
    logic [23:0]                  scan_start_reg, scan_start_next;
    logic [23:0]                  scan_end_reg, scan_end_next;
    logic                         prev_ff_reg, prev_ff_next;
    logic [2:0]                   err_reg, err_next;
    logic                         soi_reg, soi_next;
    logic                         sof_reg, sof_next;
    logic                         done_reg, done_next;

    logic [7:0]  b;
    logic [23:0] pos24;
    logic [15:0] seglen;
    logic        take;
    logic        fin;
    logic        in_sos;
    logic [2:0]  status;

    assign b      = item.data_byte;
    assign pos24  = 24'(pos_reg);
    assign seglen = {rem_reg[15:8], b};
    assign take   = step && (pos_reg < jhps_pkg::POS_LIMIT);

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        marker_next     = marker_reg;
        idx_next        = idx_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        type_next       = type_reg;
        dqt_cnt_next    = dqt_cnt_reg;
        tbl0_next       = tbl0_reg;
        tbl1_next       = tbl1_reg;
        scan_start_next = scan_start_reg;
        scan_end_next   = scan_end_reg;
        prev_ff_next    = prev_ff_reg;
        err_next        = err_reg;
        soi_next        = soi_reg;
        sof_next        = sof_reg;
        done_next       = done_reg;
        fin             = 1'b0;

        if (take)
        begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                jhps_pkg::PH_START:
                begin
                    if (b == jhps_pkg::MK_FF)
                    begin
                        phase_next = jhps_pkg::PH_SOI;
                    end
                    else
                    begin
                        err_next   = jhps_pkg::ST_NO_SOI;
                        phase_next = jhps_pkg::PH_ERR;
                    end
                end
                jhps_pkg::PH_SOI:
                begin
                    if (b == jhps_pkg::MK_SOI)
                    begin
                        soi_next   = 1'b1;
                        phase_next = jhps_pkg::PH_FRAME;
                    end
                    else
                    begin
                        err_next   = jhps_pkg::ST_NO_SOI;
                        phase_next = jhps_pkg::PH_ERR;
                    end
                end
                jhps_pkg::PH_FRAME:
                begin
                    if (b == jhps_pkg::MK_FF)
                    begin
                        phase_next = jhps_pkg::PH_TYPE;
                    end
                    else
                    begin
                        err_next   = jhps_pkg::ST_BAD_FRAME;
                        phase_next = jhps_pkg::PH_ERR;
                    end
                end
                jhps_pkg::PH_TYPE:
                begin
                    // 0xFF here is a fill byte: stay put
                    if (b != jhps_pkg::MK_FF)
                    begin
                        marker_next = b;
                        if (b == jhps_pkg::MK_SOI || b == jhps_pkg::MK_TEM ||
                            (b >= jhps_pkg::MK_RST0 && b <= jhps_pkg::MK_RST7))
                        begin
                            phase_next = jhps_pkg::PH_FRAME;
                        end
                        else if (b == jhps_pkg::MK_EOI)
                        begin
                            err_next   = jhps_pkg::ST_NO_SOS;
                            phase_next = jhps_pkg::PH_ERR;
                        end
                        else
                        begin
                            if (b == jhps_pkg::MK_DQT && dqt_cnt_reg != 2'd2)
                            begin
                                if (dqt_cnt_reg == 2'd0)
                                    tbl0_next = pos24 + 24'd4;
                                else
                                    tbl1_next = pos24 + 24'd4;
                                dqt_cnt_next = dqt_cnt_reg + 2'd1;
                            end
                            phase_next = jhps_pkg::PH_LENHI;
                        end
                    end
                end
                jhps_pkg::PH_LENHI:
                begin
                    rem_next   = {b, 8'h00};
                    phase_next = jhps_pkg::PH_LENLO;
                end
                jhps_pkg::PH_LENLO:
                begin
                    if (seglen < 16'd2)
                    begin
                        err_next   = jhps_pkg::ST_BAD_FRAME;
                        phase_next = jhps_pkg::PH_ERR;
                    end
                    else
                    begin
                        rem_next = seglen - 16'd2;
                        idx_next = 16'd0;
                        if (seglen == 16'd2)
                            fin = 1'b1;
                        else
                            phase_next = jhps_pkg::PH_BODY;
                    end
                end
                jhps_pkg::PH_BODY:
                begin
                    if (marker_reg == jhps_pkg::MK_SOF0 && !sof_reg)
                    begin
                        if (idx_reg == SOF_HGT_HI)
                            height_next = {b, 8'h00};
                        else if (idx_reg == SOF_HGT_LO)
                            height_next = {height_reg[15:8], b};
                        else if (idx_reg == SOF_WID_HI)
                            width_next = {b, 8'h00};
                        else if (idx_reg == SOF_WID_LO)
                            width_next = {width_reg[15:8], b};
                        else if (idx_reg == SOF_SAMP)
                            type_next = (b == jhps_pkg::SAMP_H2V2) && (rem_reg >= 16'd2);
                    end
                    idx_next = idx_reg + 16'd1;
                    rem_next = rem_reg - 16'd1;
                    if (rem_reg == 16'd1)
                        fin = 1'b1;
                end
                jhps_pkg::PH_SCAN:
                begin
                    if (prev_ff_reg)
                    begin
                        if (b == 8'h00)
                        begin
                            prev_ff_next = 1'b0;     // stuffed zero
                        end
                        else if (b == jhps_pkg::MK_EOI)
                        begin
                            scan_end_next = pos24 - 24'd1;
                            done_next     = 1'b1;
                            phase_next    = jhps_pkg::PH_DONE;
                        end
                        else
                        begin
                            err_next   = jhps_pkg::ST_NO_EOI;
                            phase_next = jhps_pkg::PH_ERR;
                        end
                    end
                    else if (b == jhps_pkg::MK_FF)
                    begin
                        prev_ff_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (fin)
            begin
                if (marker_reg == jhps_pkg::MK_SOF0)
                    sof_next = 1'b1;
                if (marker_reg == jhps_pkg::MK_SOS)
                begin
                    scan_start_next = pos24 + 24'd1;
                    prev_ff_next    = 1'b0;
                    phase_next      = jhps_pkg::PH_SCAN;
                end
                else
                begin
                    phase_next = jhps_pkg::PH_FRAME;
                end
            end
        end

        // Summary is built from the post-update state
        in_sos = (phase_next == jhps_pkg::PH_SCAN) ||
                 (marker_next == jhps_pkg::MK_SOS &&
                  (phase_next == jhps_pkg::PH_LENHI || phase_next == jhps_pkg::PH_LENLO ||
                   phase_next == jhps_pkg::PH_BODY));
        priority if (err_next != jhps_pkg::ST_OK)
            status = err_next;
        else if (done_next)
            status = jhps_pkg::ST_OK;
        else if (!soi_next)
            status = jhps_pkg::ST_NO_SOI;
        else if (in_sos)
            status = jhps_pkg::ST_NO_EOI;
        else
            status = jhps_pkg::ST_NO_SOS;

        res.status          = status;
        res.image_width     = width_next;
        res.image_height    = height_next;
        res.subsample_type  = type_next;
        res.qtable0_present = (dqt_cnt_next != 2'd0);
        res.qtable0_offset  = tbl0_next;
        res.qtable1_present = dqt_cnt_next[1];
        res.qtable1_offset  = tbl1_next;
        res.payload_offset  = scan_start_next;
        res.payload_length  = (status == jhps_pkg::ST_OK) ?
                              (scan_end_next - scan_start_next) : 24'd0;

        res_fire = step && item.last_byte;

        // End of image: start over for the next one
        if (res_fire)
        begin
            phase_next      = jhps_pkg::PH_START;
            pos_next        = '0;
            rem_next        = '0;
            marker_next     = '0;
            idx_next        = '0;
            width_next      = '0;
            height_next     = '0;
            type_next       = 1'b0;
            dqt_cnt_next    = '0;
            tbl0_next       = '0;
            tbl1_next       = '0;
            scan_start_next = '0;
            scan_end_next   = '0;
            prev_ff_next    = 1'b0;
            err_next        = jhps_pkg::ST_OK;
            soi_next        = 1'b0;
            sof_next        = 1'b0;
            done_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= jhps_pkg::PH_START;
            pos_reg        <= '0;
            rem_reg        <= '0;
            marker_reg     <= '0;
            idx_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            type_reg       <= 1'b0;
            dqt_cnt_reg    <= '0;
            tbl0_reg       <= '0;
            tbl1_reg       <= '0;
            scan_start_reg <= '0;
            scan_end_reg   <= '0;
            prev_ff_reg    <= 1'b0;
            err_reg        <= jhps_pkg::ST_OK;
            soi_reg        <= 1'b0;
            sof_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            marker_reg     <= marker_next;
            idx_reg        <= idx_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            type_reg       <= type_next;
            dqt_cnt_reg    <= dqt_cnt_next;
            tbl0_reg       <= tbl0_next;
            tbl1_reg       <= tbl1_next;
            scan_start_reg <= scan_start_next;
            scan_end_reg   <= scan_end_next;
            prev_ff_reg    <= prev_ff_next;
            err_reg        <= err_next;
            soi_reg        <= soi_next;
            sof_reg        <= sof_next;
            done_reg       <= done_next;
        end
    end

endmodule

### hdl/jpeg_header_and_payload_scanner.sv
// JPEG header and payload scanner, top level: byte channel, parser, result register.
// Depends on jhps_pkg and jhps_parser.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+---------------------------------
//   byte     | byte_valid / byte_ready       | byte_data   (jhps_pkg::byte_item_t)
//   result   | result_valid / result_ready   | result      (jhps_pkg::result_item_t)
//
// One byte per cycle while byte_ready is high: the parser state updates in the
// cycle of the transaction. The summary for an image is registered on the byte
// flagged last_byte and shows on the result channel the next cycle. byte_ready
// drops only while a result is held and result_ready is low. Reset clears all
// parser state and the result register; no clearing pass is needed.
`timescale 1ns / 1ps

module jpeg_header_and_payload_scanner
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  jhps_pkg::byte_item_t   byte_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output jhps_pkg::result_item_t result
);

    logic                   step;
    logic                   res_fire;
    jhps_pkg::result_item_t res;
    logic                   out_valid_reg, out_valid_next;
    jhps_pkg::result_item_t out_reg;

    assign byte_ready = !out_valid_reg || result_ready;
    assign step       = byte_valid && byte_ready;

    jhps_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (byte_data),
        .res_fire (res_fire),
        .res      (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (res_fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (res_fire)
            out_reg <= res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
